@@ rtl/cis_pkg.sv @@
// Shared types, constants and helpers for the cone isolation sum core.
`default_nettype none

package cis_pkg;

    localparam int SUM_WIDTH_DEF = 21;

    localparam int ANGLE_W   = 11;
    localparam int DIFF_W    = ANGLE_W + 1;
    localparam int SQ_W      = 22;
    localparam int DR2_W     = SQ_W + 1;
    localparam int QTY_W     = 16;
    localparam int TYPE_W    = 3;
    localparam int OUT_W     = 21;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int RG_W      = 2 * QTY_W;
    localparam int PROD_W    = RG_W + QTY_W;
    localparam int TERM_SHIFT = 18;
    localparam int TERM_W    = PROD_W - TERM_SHIFT;

    // angles in 1/256: barrel edge 1.479, pi and two pi
    localparam logic [DIFF_W-1:0]        BARREL_ETA_MAX = 12'd378;
    localparam logic signed [DIFF_W-1:0] PI_Q           = 12'sd804;
    localparam logic signed [DIFF_W-1:0] NEG_PI_Q       = -12'sd804;
    localparam logic signed [DIFF_W-1:0] TWO_PI_Q       = 12'sd1608;

    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (TERM_SHIFT - 1);

    localparam int OUT_MAX_INT = (1 << (OUT_W - 1)) - 1;
    localparam int OUT_MIN_INT = -(1 << (OUT_W - 1));

    // register reset values
    localparam logic [QTY_W-1:0]  CONE_RADIUS_SQ_RST = 16'd5898;
    localparam logic [CFG_W-1:0]  BARREL_CUTS_RST    = 64'd28991922601197568;
    localparam logic [CFG_W-1:0]  ENDCAP_CUTS_RST    = 64'd13229323905400832;
    localparam logic [TYPE_W-1:0] SELECTED_TYPE_RST  = 3'd5;
    localparam logic              RHO_ENABLE_RST     = 1'b0;
    localparam logic [QTY_W-1:0]  RHO_LIMIT_RST      = 16'd65535;
    localparam logic [QTY_W-1:0]  RHO_GAIN_RST       = 16'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CONE_RADIUS_SQ = 3'd0,
        REG_BARREL_CUTS    = 3'd1,
        REG_ENDCAP_CUTS    = 3'd2,
        REG_SELECTED_TYPE  = 3'd3,
        REG_RHO_ENABLE     = 3'd4,
        REG_RHO_LIMIT      = 3'd5,
        REG_RHO_GAIN       = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic load;
        logic diff;
        logic square;
        logic accum;
        logic finish;
    } cis_cmd_t;

    typedef struct packed {
        logic last;
        logic out_free;
    } cis_status_t;

    function automatic logic [DIFF_W-1:0] abs_diff(input logic signed [DIFF_W-1:0] v);
        return v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
    endfunction

endpackage

`default_nettype wire

@@ rtl/cis_ctrl.sv @@
// Sequencer for the cone isolation sum: one beat through four steps, plus a result step.
`default_nettype none

module cis_ctrl
    import cis_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    output cis_cmd_t         cmd,
    input  wire cis_status_t status
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SQUARE,
        ST_ACCUM,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && ready_reg) begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:   state_next = ST_SQUARE;
            ST_SQUARE: state_next = ST_ACCUM;
            ST_ACCUM:  state_next = status.last ? ST_FINISH : ST_IDLE;
            ST_FINISH: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
        ready_next = (state_next == ST_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign s_ready    = ready_reg;
    assign cmd.load   = s_valid && ready_reg;
    assign cmd.diff   = (state_reg == ST_DIFF);
    assign cmd.square = (state_reg == ST_SQUARE);
    assign cmd.accum  = (state_reg == ST_ACCUM);
    assign cmd.finish = (state_reg == ST_FINISH) && status.out_free;

endmodule

`default_nettype wire

@@ rtl/cis_dp.sv @@
// Datapath: config registers, cut logic, squares, accumulator, rho term and result register.
`default_nettype none

module cis_dp
    import cis_pkg::*;
#(
    parameter int SUM_WIDTH = SUM_WIDTH_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [CFG_W-1:0]         cfg_data,
    input  wire logic signed [ANGLE_W-1:0] s_electron_eta,
    input  wire logic signed [ANGLE_W-1:0] s_electron_phi,
    input  wire logic signed [ANGLE_W-1:0] s_cluster_eta,
    input  wire logic                     s_cand_valid,
    input  wire logic [TYPE_W-1:0]        s_cand_type,
    input  wire logic [QTY_W-1:0]         s_cand_pt,
    input  wire logic [QTY_W-1:0]         s_cand_energy,
    input  wire logic signed [ANGLE_W-1:0] s_cand_eta,
    input  wire logic signed [ANGLE_W-1:0] s_cand_phi,
    input  wire logic [QTY_W-1:0]         s_event_rho,
    input  wire logic                     s_last,
    input  wire cis_cmd_t                 cmd,
    output cis_status_t                   status,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic signed [OUT_W-1:0]       m_isolation_sum,
    output logic                          m_saturated
);

    localparam logic [SUM_WIDTH:0] ACC_MAX = {2'b00, {(SUM_WIDTH - 1){1'b1}}};
    localparam int FIN_W = ((SUM_WIDTH > TERM_W) ? SUM_WIDTH : TERM_W) + 2;
    localparam logic signed [FIN_W-1:0] FIN_MAX = FIN_W'(OUT_MAX_INT);
    localparam logic signed [FIN_W-1:0] FIN_MIN = FIN_W'(OUT_MIN_INT);

    // configuration
    logic [QTY_W-1:0]  cone_radius_sq_reg;
    logic [CFG_W-1:0]  barrel_cuts_reg;
    logic [CFG_W-1:0]  endcap_cuts_reg;
    logic [TYPE_W-1:0] selected_type_reg;
    logic              rho_enable_reg;
    logic [QTY_W-1:0]  rho_limit_reg;
    logic [QTY_W-1:0]  rho_gain_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cone_radius_sq_reg <= CONE_RADIUS_SQ_RST;
            barrel_cuts_reg    <= BARREL_CUTS_RST;
            endcap_cuts_reg    <= ENDCAP_CUTS_RST;
            selected_type_reg  <= SELECTED_TYPE_RST;
            rho_enable_reg     <= RHO_ENABLE_RST;
            rho_limit_reg      <= RHO_LIMIT_RST;
            rho_gain_reg       <= RHO_GAIN_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_CONE_RADIUS_SQ: cone_radius_sq_reg <= cfg_data[QTY_W-1:0];
                REG_BARREL_CUTS:    barrel_cuts_reg    <= cfg_data;
                REG_ENDCAP_CUTS:    endcap_cuts_reg    <= cfg_data;
                REG_SELECTED_TYPE:  selected_type_reg  <= cfg_data[TYPE_W-1:0];
                REG_RHO_ENABLE:     rho_enable_reg     <= cfg_data[0];
                REG_RHO_LIMIT:      rho_limit_reg      <= cfg_data[QTY_W-1:0];
                REG_RHO_GAIN:       rho_gain_reg       <= cfg_data[QTY_W-1:0];
                default: ;
            endcase
        end
    end

    // captured beat
    logic [ANGLE_W-1:0] e_eta_reg, e_phi_reg, c_eta_reg, p_eta_reg, p_phi_reg;
    logic               valid_reg, last_reg;
    logic [TYPE_W-1:0]  type_reg;
    logic [QTY_W-1:0]   pt_reg, energy_reg, rho_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            e_eta_reg  <= s_electron_eta;
            e_phi_reg  <= s_electron_phi;
            c_eta_reg  <= s_cluster_eta;
            valid_reg  <= s_cand_valid;
            type_reg   <= s_cand_type;
            pt_reg     <= s_cand_pt;
            energy_reg <= s_cand_energy;
            p_eta_reg  <= s_cand_eta;
            p_phi_reg  <= s_cand_phi;
            rho_reg    <= s_event_rho;
            last_reg   <= s_last;
        end
    end

    // step 1: differences, phi wrap, region and threshold cuts, rho times gain
    logic signed [DIFF_W-1:0] e_eta_x, e_phi_x, c_eta_x, p_eta_x, p_phi_x;
    logic signed [DIFF_W-1:0] deta_raw, dphi_raw, dphi_wrap;
    logic [DIFF_W-1:0]        deta_abs;
    logic                     barrel, c_barrel, hit_pre;
    logic [CFG_W-1:0]         cuts;
    logic [QTY_W-1:0]         cut_val, rho_clip, area;

    assign e_eta_x = {e_eta_reg[ANGLE_W-1], e_eta_reg};
    assign e_phi_x = {e_phi_reg[ANGLE_W-1], e_phi_reg};
    assign c_eta_x = {c_eta_reg[ANGLE_W-1], c_eta_reg};
    assign p_eta_x = {p_eta_reg[ANGLE_W-1], p_eta_reg};
    assign p_phi_x = {p_phi_reg[ANGLE_W-1], p_phi_reg};

    always_comb begin
        deta_raw = p_eta_x - e_eta_x;
        dphi_raw = p_phi_x - e_phi_x;
        deta_abs = abs_diff(deta_raw);
        priority if (dphi_raw > PI_Q) begin
            dphi_wrap = dphi_raw - TWO_PI_Q;
        end else if (dphi_raw < NEG_PI_Q) begin
            dphi_wrap = dphi_raw + TWO_PI_Q;
        end else begin
            dphi_wrap = dphi_raw;
        end
        barrel   = (abs_diff(e_eta_x) <= BARREL_ETA_MAX);
        c_barrel = (abs_diff(c_eta_x) <= BARREL_ETA_MAX);
        cuts     = barrel ? barrel_cuts_reg : endcap_cuts_reg;
        cut_val  = barrel ? pt_reg : energy_reg;
        hit_pre  = valid_reg && (type_reg == selected_type_reg)
                   && (cut_val >= cuts[47:32])
                   && ({{(QTY_W - DIFF_W){1'b0}}, deta_abs} >= cuts[31:16]);
        rho_clip = (rho_reg > rho_limit_reg) ? rho_limit_reg : rho_reg;
        area     = c_barrel ? barrel_cuts_reg[63:48] : endcap_cuts_reg[63:48];
    end

    logic                     hit_reg;
    logic [QTY_W-1:0]         veto_reg, area_reg;
    logic [DIFF_W-1:0]        deta_reg;
    logic signed [DIFF_W-1:0] dphi_reg;
    logic [RG_W-1:0]          rho_gain_prod_reg;

    always_ff @(posedge aclk) begin
        if (cmd.diff) begin
            hit_reg           <= hit_pre;
            veto_reg          <= cuts[15:0];
            deta_reg          <= deta_abs;
            dphi_reg          <= dphi_wrap;
            area_reg          <= area;
            rho_gain_prod_reg <= {{QTY_W{1'b0}}, rho_clip} * {{QTY_W{1'b0}}, rho_gain_reg};
        end
    end

    // step 2: squares and rho times area
    logic [2*DIFF_W-1:0]        deta_sq_full;
    logic signed [2*DIFF_W-1:0] dphi_sq_full;
    logic [SQ_W-1:0]            deta_sq_reg, dphi_sq_reg;
    logic [PROD_W-1:0]          rho_prod_reg;

    assign deta_sq_full = deta_reg * deta_reg;
    assign dphi_sq_full = dphi_reg * dphi_reg;

    always_ff @(posedge aclk) begin
        if (cmd.square) begin
            deta_sq_reg  <= deta_sq_full[SQ_W-1:0];
            dphi_sq_reg  <= dphi_sq_full[SQ_W-1:0];
            rho_prod_reg <= {{QTY_W{1'b0}}, rho_gain_prod_reg}
                            * {{RG_W{1'b0}}, area_reg};
        end
    end

    // step 3: cone test, saturating accumulate, rounded rho term
    logic [DR2_W-1:0]     dr2;
    logic                 cone_hit;
    logic [SUM_WIDTH:0]   acc_sum;
    logic [PROD_W-1:0]    rho_round;
    logic [SUM_WIDTH-1:0] acc_reg, acc_next;
    logic                 clip_reg, clip_next;
    logic [TERM_W-1:0]    term_reg;

    always_comb begin
        dr2       = {1'b0, deta_sq_reg} + {1'b0, dphi_sq_reg};
        cone_hit  = hit_reg
                    && (dr2 <= {{(DR2_W - QTY_W){1'b0}}, cone_radius_sq_reg})
                    && (dr2 >= {{(DR2_W - QTY_W){1'b0}}, veto_reg});
        acc_sum   = {1'b0, acc_reg} + {{(SUM_WIDTH + 1 - QTY_W){1'b0}}, pt_reg};
        rho_round = rho_prod_reg + ROUND_HALF;
        acc_next  = acc_reg;
        clip_next = clip_reg;
        if (cmd.finish) begin
            acc_next  = '0;
            clip_next = 1'b0;
        end else if (cmd.accum && cone_hit) begin
            if (acc_sum > ACC_MAX) begin
                acc_next  = ACC_MAX[SUM_WIDTH-1:0];
                clip_next = 1'b1;
            end else begin
                acc_next = acc_sum[SUM_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= '0;
            clip_reg <= 1'b0;
        end else begin
            acc_reg  <= acc_next;
            clip_reg <= clip_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accum) begin
            term_reg <= rho_enable_reg ? rho_round[PROD_W-1:TERM_SHIFT] : '0;
        end
    end

    // step 4: subtract, clip to output range, result register
    logic signed [FIN_W-1:0] fin_val;
    logic signed [OUT_W-1:0] fin_sum;
    logic                    fin_sat;

    always_comb begin
        fin_val = $signed({{(FIN_W - SUM_WIDTH){1'b0}}, acc_reg})
                  - $signed({{(FIN_W - TERM_W){1'b0}}, term_reg});
        fin_sum = fin_val[OUT_W-1:0];
        fin_sat = clip_reg;
        priority if (fin_val > FIN_MAX) begin
            fin_sum = FIN_MAX[OUT_W-1:0];
            fin_sat = 1'b1;
        end else if (fin_val < FIN_MIN) begin
            fin_sum = FIN_MIN[OUT_W-1:0];
            fin_sat = 1'b1;
        end else begin
            fin_sum = fin_val[OUT_W-1:0];
        end
    end

    logic                    m_valid_reg;
    logic signed [OUT_W-1:0] m_sum_reg;
    logic                    m_sat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_sum_reg <= fin_sum;
            m_sat_reg <= fin_sat;
        end
    end

    assign status.last     = last_reg;
    assign status.out_free = !m_valid_reg || m_ready;
    assign m_valid         = m_valid_reg;
    assign m_isolation_sum = m_sum_reg;
    assign m_saturated     = m_sat_reg;

endmodule

`default_nettype wire

@@ rtl/cone_isolation_sum_core.sv @@
// Top level of the cone isolation sum core: sequencer plus datapath.
// Each input beat passes through capture, differences, squares and accumulate
// steps before the next beat is taken; the beat that closes a group adds a
// result step, which waits while the result register still holds an untaken
// result and then loads the new result and raises m_valid.
// The step chain sets the rate.
// aresetn (synchronous, active low) restores register defaults, empties the sum.
`default_nettype none

module cone_isolation_sum_core
    import cis_pkg::*;
#(
    parameter int SUM_WIDTH = SUM_WIDTH_DEF   // accumulator width, 16 to 32
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    // config write port
    input  wire logic                      cfg_we,
    input  wire logic [CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [CFG_W-1:0]          cfg_data,
    // candidate beats
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic signed [ANGLE_W-1:0] s_electron_eta,
    input  wire logic signed [ANGLE_W-1:0] s_electron_phi,
    input  wire logic signed [ANGLE_W-1:0] s_cluster_eta,
    input  wire logic                      s_cand_valid,
    input  wire logic [TYPE_W-1:0]         s_cand_type,
    input  wire logic [QTY_W-1:0]          s_cand_pt,
    input  wire logic [QTY_W-1:0]          s_cand_energy,
    input  wire logic signed [ANGLE_W-1:0] s_cand_eta,
    input  wire logic signed [ANGLE_W-1:0] s_cand_phi,
    input  wire logic [QTY_W-1:0]          s_event_rho,
    input  wire logic                      s_last,
    // result beats, one per group
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic signed [OUT_W-1:0]        m_isolation_sum,
    output logic                           m_saturated
);

    // Sequencer walks each beat through the datapath steps; a beat with
    // last set also waits in the result step until the output register
    // is free, so nothing is overwritten while a result is held.
    cis_cmd_t    cmd;
    cis_status_t status;

    cis_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .status  (status)
    );

    // Datapath: cut tests and phi wrap, two 12x12 squares, dR^2 window,
    // saturating pt sum; the rho term (clip, x gain, x area, round) runs
    // alongside in the same steps and is subtracted on the closing beat.
    cis_dp #(
        .SUM_WIDTH (SUM_WIDTH)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_electron_eta  (s_electron_eta),
        .s_electron_phi  (s_electron_phi),
        .s_cluster_eta   (s_cluster_eta),
        .s_cand_valid    (s_cand_valid),
        .s_cand_type     (s_cand_type),
        .s_cand_pt       (s_cand_pt),
        .s_cand_energy   (s_cand_energy),
        .s_cand_eta      (s_cand_eta),
        .s_cand_phi      (s_cand_phi),
        .s_event_rho     (s_event_rho),
        .s_last          (s_last),
        .cmd             (cmd),
        .status          (status),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_isolation_sum (m_isolation_sum),
        .m_saturated     (m_saturated)
    );

endmodule

`default_nettype wire

@@ rtl/cis_checker.sv @@
// Port-level checks for the cone isolation sum core, bound to the top level.
`default_nettype none

module cis_checker
    import cis_pkg::*;
(
    input wire logic                      aclk,
    input wire logic                      aresetn,
    input wire logic                      s_valid,
    input wire logic                      s_ready,
    input wire logic                      s_last,
    input wire logic                      m_valid,
    input wire logic                      m_ready,
    input wire logic signed [OUT_W-1:0]   m_isolation_sum,
    input wire logic                      m_saturated
);

    // a taken beat closes the input until its steps are done
    a_busy_after_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("s_ready high right after a beat was taken");

    // a beat that does not close a group frees the input again once its steps are done
    a_beat_rate: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_last) |-> ##4 s_ready)
        else $error("input not ready four cycles after a non-closing beat");

    // a fresh result only follows a closing input beat
    a_result_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready && s_last, 5))
        else $error("result beat without a closing input beat");

    // a held result keeps its value
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_isolation_sum)
                                   && $stable(m_saturated)))
        else $error("result beat changed while stalled");

endmodule

bind cone_isolation_sum_core cis_checker u_cis_checker (.*);

`default_nettype wire
